### rtl/core/color_channels_to_hsl_defines.svh
// Assertion helpers for the color converter checker.
`ifndef COLOR_CHANNELS_TO_HSL_DEFINES_SVH
`define COLOR_CHANNELS_TO_HSL_DEFINES_SVH

// same-cycle implication
`define CCH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cch_pkg.sv
// ----------------------------------------------------------------------------
// cch_pkg
// Word types and fixed scale constants of the color-to-HSL converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cch_pkg;

  typedef struct packed {
    logic [7:0] red_reading;
    logic [7:0] green_reading;
    logic [7:0] blue_reading;
    logic [7:0] clear_reading;
  } in_word_t;

  typedef struct packed {
    logic [11:0] hue_tenths;
    logic [9:0]  saturation_tenths;
    logic [9:0]  lightness_tenths;
    logic        is_grey;
  } out_word_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int OFFSET_NUM  = 3;
  localparam int LIGHT_SCALE = 500;
  localparam int SAT_SCALE   = 1000;
  localparam int HUE_SCALE   = 600;

endpackage

`default_nettype wire

### rtl/core/cch_div.sv
// ----------------------------------------------------------------------------
// cch_div
// Pipelined restoring divider, one quotient bit per stage, shared enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cch_div #(
  parameter int NW = 24,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [NW-1:0] qn_r  [NW];
  logic [DW-1:0] rem_r [NW-1];
  logic [DW-1:0] den_r [NW-1];

  // a zero divisor yields an all-ones quotient
  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] qn_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign qn_in  = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign qn_in  = qn_r[s-1];
      assign den_in = den_r[s-1];
    end

    assign trial = {rem_in, qn_in[NW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (adv) begin
        qn_r[s] <= {qn_in[NW-2:0], fits};
      end
    end

    if (s < NW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[s] <= fits ? diff[DW-1:0] : trial[DW-1:0];
          den_r[s] <= den_in;
        end
      end
    end
  end

  assign quo = qn_r[NW-1];

endmodule

`default_nettype wire

### rtl/core/cch_fifo.sv
// ----------------------------------------------------------------------------
// cch_fifo
// Small register queue with count-based full and empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cch_fifo import cch_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [W-1:0] mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full    = cnt_r == (AW+1)'(QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 1'b1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/core/cch_front.sv
// ----------------------------------------------------------------------------
// cch_front
// Takes reading words and forms the three clipped channel fractions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cch_front import cch_pkg::*; #(
  parameter int RB = 8,
  parameter int FB = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  in_word_t          word,
  output logic              full,
  output logic              q_wr,
  output logic [3*FB+2:0]   q_data,
  input  logic              q_full
);

  localparam int NW = RB + FB;
  localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

  logic [RB-1:0] red, green, blue, clr;
  logic [NW-1:0] num_ch, num_off;
  logic [NW-1:0] q_off, q_r, q_g, q_b;
  logic          vld_r [NW];
  logic          adv;
  logic [FB:0]   t_off, t_r, t_g, t_b;
  logic [FB+1:0] s_r, s_g, s_b;
  logic [FB:0]   f_r, f_g, f_b;

  assign red     = RB'(word.red_reading);
  assign green   = RB'(word.green_reading);
  assign blue    = RB'(word.blue_reading);
  assign clr     = RB'(word.clear_reading);
  assign num_ch  = NW'(clr) << FB;
  assign num_off = NW'(OFFSET_NUM) << FB;

  assign adv  = !(vld_r[NW-1] && q_full);
  assign full = !adv;

  cch_div #(.NW(NW), .DW(RB)) u_div_off (.clk, .adv, .num(num_off), .den(clr),   .quo(q_off));
  cch_div #(.NW(NW), .DW(RB)) u_div_r   (.clk, .adv, .num(num_ch),  .den(red),   .quo(q_r));
  cch_div #(.NW(NW), .DW(RB)) u_div_g   (.clk, .adv, .num(num_ch),  .den(green), .quo(q_g));
  cch_div #(.NW(NW), .DW(RB)) u_div_b   (.clk, .adv, .num(num_ch),  .den(blue),  .quo(q_b));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NW; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= push;
      for (int i = 1; i < NW; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_comb begin
    t_off = (q_off > NW'(ONE)) ? ONE : q_off[FB:0];
    t_r   = (q_r   > NW'(ONE)) ? ONE : q_r[FB:0];
    t_g   = (q_g   > NW'(ONE)) ? ONE : q_g[FB:0];
    t_b   = (q_b   > NW'(ONE)) ? ONE : q_b[FB:0];
    s_r   = {1'b0, t_off} + {1'b0, t_r};
    s_g   = {1'b0, t_off} + {1'b0, t_g};
    s_b   = {1'b0, t_off} + {1'b0, t_b};
    f_r   = (s_r > {1'b0, ONE}) ? ONE : s_r[FB:0];
    f_g   = (s_g > {1'b0, ONE}) ? ONE : s_g[FB:0];
    f_b   = (s_b > {1'b0, ONE}) ? ONE : s_b[FB:0];
  end

  assign q_wr   = vld_r[NW-1] && !q_full;
  assign q_data = {f_r, f_g, f_b};

endmodule

`default_nettype wire

### rtl/core/cch_back.sv
// ----------------------------------------------------------------------------
// cch_back
// Turns channel fractions into hue, saturation and lightness tenths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cch_back import cch_pkg::*; #(
  parameter int FB = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  logic [3*FB+2:0] q_data,
  output logic            q_pop,
  output logic            o_wr,
  output out_word_t       o_data,
  input  logic            o_full
);

  localparam int NW = FB + 13;
  localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

  logic            adv;
  logic [FB:0]     r, g, b, mx, mn, delta;
  logic [FB+1:0]   sum;
  logic [FB:0]     den;
  logic [FB+3:0]   dx;
  logic signed [FB+3:0] hs;

  logic            vld0_r, vld1_r;
  logic [FB:0]     delta0_r, den0_r;
  logic [FB+1:0]   sum0_r;
  logic [FB+2:0]   h0_r;

  logic [FB+10:0]  lprod;
  logic [9:0]      light1_r;
  logic            grey1_r;
  logic [NW-1:0]   snum1_r, hnum1_r;
  logic [FB:0]     den1_r, delta1_r;

  logic            vd_r    [NW];
  logic [9:0]      light_r [NW];
  logic            grey_r  [NW];
  logic [NW-1:0]   q_h, q_s;

  assign adv   = !(vd_r[NW-1] && o_full);
  assign q_pop = !q_empty && adv;

  always_comb begin
    {r, g, b} = q_data;
    mx = (r >= b) ? r : b;
    if (g >= mx) mx = g;
    mn = (r <= b) ? r : b;
    if (g <= mn) mn = g;
    delta = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};
    // 2*ONE - sum never exceeds ONE on the high-lightness side
    den   = (sum < {1'b0, ONE}) ? sum[FB:0] : (FB+1)'({ONE, 1'b0} - sum);
    dx    = {3'b0, delta};
    // red wins ties over green, green over blue
    if (r == mx) begin
      hs = $signed({3'b0, g}) - $signed({3'b0, b});
    end else if (g == mx) begin
      hs = $signed(dx << 1) + $signed({3'b0, b}) - $signed({3'b0, r});
    end else begin
      hs = $signed(dx << 2) + $signed({3'b0, r}) - $signed({3'b0, g});
    end
    if (hs < 0) hs = hs + $signed((dx << 2) + (dx << 1));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      delta0_r <= delta;
      sum0_r   <= sum;
      den0_r   <= den;
      h0_r     <= hs[FB+2:0];
    end
  end

  assign lprod = (FB+11)'(sum0_r) * (FB+11)'(LIGHT_SCALE);

  always_ff @(posedge clk) begin
    if (adv) begin
      light1_r <= lprod[FB+9:FB];
      grey1_r  <= delta0_r == '0;
      snum1_r  <= NW'(delta0_r) * NW'(SAT_SCALE);
      hnum1_r  <= NW'(h0_r) * NW'(HUE_SCALE);
      den1_r   <= den0_r;
      delta1_r <= delta0_r;
    end
  end

  cch_div #(.NW(NW), .DW(FB+1)) u_div_hue (.clk, .adv, .num(hnum1_r), .den(delta1_r), .quo(q_h));
  cch_div #(.NW(NW), .DW(FB+1)) u_div_sat (.clk, .adv, .num(snum1_r), .den(den1_r),   .quo(q_s));

  always_ff @(posedge clk) begin
    if (adv) begin
      light_r[0] <= light1_r;
      grey_r[0]  <= grey1_r;
      for (int i = 1; i < NW; i++) begin
        light_r[i] <= light_r[i-1];
        grey_r[i]  <= grey_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      for (int i = 0; i < NW; i++) vd_r[i] <= 1'b0;
    end else if (adv) begin
      vld0_r  <= q_pop;
      vld1_r  <= vld0_r;
      vd_r[0] <= vld1_r;
      for (int i = 1; i < NW; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  assign o_wr = vd_r[NW-1] && !o_full;

  always_comb begin
    o_data.is_grey           = grey_r[NW-1];
    o_data.lightness_tenths  = light_r[NW-1];
    o_data.hue_tenths        = grey_r[NW-1] ? 12'd0 : q_h[11:0];
    o_data.saturation_tenths = grey_r[NW-1] ? 10'd0 : q_s[9:0];
  end

endmodule

`default_nettype wire

### rtl/core/color_channels_to_hsl.sv
// A pushed word passes the one-bit-per-stage divider pipelines of the front part,
// the middle queue, the back part's registers and divider pipelines, and the
// output queue before it shows on the output.
// Throughput: one word per cycle while out_pop keeps up.
// Reset: synchronous active-low rst_n empties both queues and all stage valids.
`timescale 1ns / 1ps
`default_nettype none

module color_channels_to_hsl import cch_pkg::*; #(
  parameter int READING_BITS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_word_t  in_word,
  input  logic      out_pop,
  output logic      out_empty,
  output out_word_t out_word
);

  localparam int MW = 3 * (FRACTION_BITS + 1);
  localparam int OW = $bits(out_word_t);

  logic          mq_wr, mq_rd, mq_full, mq_empty;
  logic [MW-1:0] mq_wdata, mq_rdata;
  logic          oq_wr, oq_full;
  out_word_t     oq_wdata;
  logic [OW-1:0] oq_rdata;

  cch_front #(.RB(READING_BITS), .FB(FRACTION_BITS)) u_front (
    .clk, .rst_n,
    .push   (in_push),
    .word   (in_word),
    .full   (in_full),
    .q_wr   (mq_wr),
    .q_data (mq_wdata),
    .q_full (mq_full)
  );

  cch_fifo #(.W(MW)) u_mid_q (
    .clk, .rst_n,
    .wr_en (mq_wr), .wr_data (mq_wdata),
    .rd_en (mq_rd), .rd_data (mq_rdata),
    .full  (mq_full), .empty (mq_empty)
  );

  cch_back #(.FB(FRACTION_BITS)) u_back (
    .clk, .rst_n,
    .q_empty (mq_empty),
    .q_data  (mq_rdata),
    .q_pop   (mq_rd),
    .o_wr    (oq_wr),
    .o_data  (oq_wdata),
    .o_full  (oq_full)
  );

  cch_fifo #(.W(OW)) u_out_q (
    .clk, .rst_n,
    .wr_en (oq_wr), .wr_data (oq_wdata),
    .rd_en (out_pop && !out_empty), .rd_data (oq_rdata),
    .full  (oq_full), .empty (out_empty)
  );

  assign out_word = out_word_t'(oq_rdata);

endmodule

`default_nettype wire

### rtl/core/cch_checker.sv
// ----------------------------------------------------------------------------
// cch_checker
// Port-level checks on the converter's output words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "color_channels_to_hsl_defines.svh"

module cch_checker import cch_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_pop,
  input wire logic      out_empty,
  input wire out_word_t out_word
);

  `CCH_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_word), "output word changed before pop")
  `CCH_ASSERT_NOW(a_grey_zero, !out_empty && out_word.is_grey, out_word.hue_tenths == 12'd0 && out_word.saturation_tenths == 10'd0, "grey word with nonzero hue or saturation")
  `CCH_ASSERT_NOW(a_hue_range, !out_empty, out_word.hue_tenths < 12'd3600, "hue out of range")
  `CCH_ASSERT_NOW(a_sl_range, !out_empty, out_word.saturation_tenths <= 10'd1000 && out_word.lightness_tenths <= 10'd1000, "saturation or lightness out of range")

endmodule

bind color_channels_to_hsl cch_checker u_cch_checker (.*);

`default_nettype wire
